@@ rtl/core/ebc_pkg.sv @@
// Shared constants, types and a helper function of the elevator bank controller.
package ebc_pkg;

  localparam int NUM_CARS    = 4;
  localparam int MAX_FLOORS  = 32;
  localparam int START_FLOOR = 1;

  localparam int FLOOR_W   = 6;
  localparam int CAR_ID_W  = 4;
  localparam int OP_W      = 2;
  localparam int MOT_W     = 2;
  localparam int MAP_W     = MAX_FLOORS;
  localparam int CAR_IDX_W = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;

  localparam logic [FLOOR_W-1:0]   FLOOR_COUNT_RST = FLOOR_W'(32);
  localparam logic [FLOOR_W-1:0]   MAX_FLOOR_VAL   = FLOOR_W'(MAX_FLOORS);
  localparam logic [FLOOR_W-1:0]   START_FLOOR_VAL = FLOOR_W'(START_FLOOR);
  localparam logic [CAR_IDX_W-1:0] LAST_CAR        = CAR_IDX_W'(NUM_CARS - 1);
  localparam logic [CAR_ID_W-1:0]  NUM_CARS_VAL    = CAR_ID_W'(NUM_CARS);

  typedef enum logic [OP_W-1:0] {
    OP_HALL = 2'd0,
    OP_CALL = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [MOT_W-1:0] {
    MOT_IDLE = 2'd0,
    MOT_UP   = 2'd1,
    MOT_DOWN = 2'd2
  } motion_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_APPLY  = 5'b00100,
    ST_TICK   = 5'b01000,
    ST_REJECT = 5'b10000
  } state_e;

  // One-hot stop map bit for a floor; floor f maps to bit f-1.
  function automatic logic [MAP_W-1:0] stop_bit(input logic [FLOOR_W-1:0] fl);
    logic [FLOOR_W-1:0] idx;
    idx = fl - FLOOR_W'(1);
    return MAP_W'(1) << idx[$clog2(MAP_W)-1:0];
  endfunction

endpackage

@@ rtl/core/elevator_bank_controller.sv @@
// Elevator bank controller: per-car SCAN scheduling with one shared car update unit.
//
// One input transaction is taken at a time; the input stalls until all of its results
// are issued. A car call goes straight to the car update, and a hall request first runs
// a nearest-car search over every car; a tick has the single car update unit visit the
// cars in order and issue one status result each. A stalled output holds the block in
// its state. Operation 3 is taken and gives no result. The floor count register may be
// written only while the block is idle.
module elevator_bank_controller
  import ebc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                floor_count_we_i,
  input  logic [FLOOR_W-1:0]  floor_count_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [FLOOR_W-1:0]  floor_i,
  input  logic [CAR_ID_W-1:0] car_number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                accepted_o,
  output logic [CAR_ID_W-1:0] car_id_o,
  output logic [FLOOR_W-1:0]  car_floor_o,
  output logic [MOT_W-1:0]    motion_o,
  output logic                doors_open_o,
  output logic                last_o
);

  state_e               state_q, state_d;
  logic [FLOOR_W-1:0]   floor_count_q;
  logic [FLOOR_W-1:0]   req_floor_q;
  logic [CAR_IDX_W-1:0] car_q, car_d;
  logic [CAR_IDX_W-1:0] best_q, best_d;
  logic [FLOOR_W-1:0]   best_dist_q, best_dist_d;

  logic [FLOOR_W-1:0]   floor_q [NUM_CARS];
  motion_e              motion_q [NUM_CARS];
  logic [MAP_W-1:0]     up_q [NUM_CARS];
  logic [MAP_W-1:0]     down_q [NUM_CARS];

  logic                 out_valid_q;
  logic                 accepted_q;
  logic [CAR_ID_W-1:0]  car_id_q;
  logic [FLOOR_W-1:0]   car_floor_q;
  logic [MOT_W-1:0]     motion_out_q;
  logic                 doors_open_q;
  logic                 last_q;

  logic                 in_accept;
  logic                 out_free;
  logic [FLOOR_W-1:0]   floor_limit;
  logic                 floor_ok;
  logic                 car_ok;
  logic [CAR_ID_W-1:0]  car_number_m1;

  logic [CAR_IDX_W-1:0] sel;
  logic [FLOOR_W-1:0]   cur_floor;
  motion_e              cur_motion;
  logic [MAP_W-1:0]     cur_up, cur_down;
  logic [FLOOR_W-1:0]   car_gap;
  logic [MAP_W-1:0]     req_bit, hit_bit;

  logic                 car_we;
  logic [FLOOR_W-1:0]   new_floor;
  motion_e              new_motion;
  logic [MAP_W-1:0]     new_up, new_down;
  logic                 new_door;

  logic                 out_load;
  logic                 out_accepted;
  logic [CAR_ID_W-1:0]  out_car_id;
  logic                 out_last;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign floor_limit   = (floor_count_q > MAX_FLOOR_VAL) ? MAX_FLOOR_VAL : floor_count_q;
  assign floor_ok      = (floor_i != '0) && (floor_i <= floor_limit);
  assign car_ok        = (car_number_i != '0) && (car_number_i <= NUM_CARS_VAL);
  assign car_number_m1 = car_number_i - CAR_ID_W'(1);

  assign sel        = (state_q == ST_APPLY) ? best_q : car_q;
  assign cur_floor  = floor_q[sel];
  assign cur_motion = motion_q[sel];
  assign cur_up     = up_q[sel];
  assign cur_down   = down_q[sel];
  assign car_gap    = (cur_floor > req_floor_q) ? (cur_floor - req_floor_q)
                                                : (req_floor_q - cur_floor);
  assign req_bit    = stop_bit(req_floor_q);

  always_comb begin
    new_floor  = cur_floor;
    new_motion = cur_motion;
    new_up     = cur_up;
    new_down   = cur_down;
    new_door   = 1'b0;
    hit_bit    = '0;
    if (state_q == ST_APPLY) begin
      if (req_floor_q > cur_floor) begin
        new_up = cur_up | req_bit;
      end else if (req_floor_q < cur_floor) begin
        new_down = cur_down | req_bit;
      end
      if ((req_floor_q != cur_floor) && (cur_motion == MOT_IDLE)) begin
        new_motion = (req_floor_q > cur_floor) ? MOT_UP : MOT_DOWN;
      end
    end else begin
      case (cur_motion)
        MOT_UP: begin
          new_floor = (cur_floor < MAX_FLOOR_VAL) ? cur_floor + FLOOR_W'(1) : cur_floor;
          hit_bit   = stop_bit(new_floor) & cur_up;
          new_door  = (hit_bit != '0);
          new_up    = cur_up & ~hit_bit;
          if (new_up == '0) begin
            new_motion = (cur_down != '0) ? MOT_DOWN : MOT_IDLE;
          end
        end
        MOT_DOWN: begin
          new_floor = (cur_floor > FLOOR_W'(1)) ? cur_floor - FLOOR_W'(1) : cur_floor;
          hit_bit   = stop_bit(new_floor) & cur_down;
          new_door  = (hit_bit != '0);
          new_down  = cur_down & ~hit_bit;
          if (new_down == '0) begin
            new_motion = (cur_up != '0) ? MOT_UP : MOT_IDLE;
          end
        end
        default: begin
          new_motion = MOT_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    car_d        = car_q;
    best_d       = best_q;
    best_dist_d  = best_dist_q;
    car_we       = 1'b0;
    out_load     = 1'b0;
    out_accepted = 1'b1;
    out_car_id   = CAR_ID_W'(sel) + CAR_ID_W'(1);
    out_last     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          car_d = '0;
          case (op_e'(operation_i))
            OP_HALL: state_d = floor_ok ? ST_SEARCH : ST_REJECT;
            OP_CALL: begin
              state_d = (floor_ok && car_ok) ? ST_APPLY : ST_REJECT;
              best_d  = car_number_m1[CAR_IDX_W-1:0];
            end
            OP_TICK: state_d = ST_TICK;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        if ((car_q == '0) || (car_gap < best_dist_q)) begin
          best_d      = car_q;
          best_dist_d = car_gap;
        end
        car_d = car_q + CAR_IDX_W'(1);
        if (car_q == LAST_CAR) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          car_we   = 1'b1;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_TICK: begin
        out_last = (car_q == LAST_CAR);
        if (out_free) begin
          car_we   = 1'b1;
          out_load = 1'b1;
          car_d    = car_q + CAR_IDX_W'(1);
          if (car_q == LAST_CAR) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_REJECT: begin
        out_accepted = 1'b0;
        out_car_id   = '0;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      floor_count_q <= FLOOR_COUNT_RST;
      car_q         <= '0;
      best_q        <= '0;
      best_dist_q   <= '0;
      out_valid_q   <= 1'b0;
      for (int c = 0; c < NUM_CARS; c++) begin
        floor_q[c]  <= START_FLOOR_VAL;
        motion_q[c] <= MOT_IDLE;
        up_q[c]     <= '0;
        down_q[c]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      car_q       <= car_d;
      best_q      <= best_d;
      best_dist_q <= best_dist_d;
      if (floor_count_we_i) begin
        floor_count_q <= floor_count_i;
      end
      if (car_we) begin
        floor_q[sel]  <= new_floor;
        motion_q[sel] <= new_motion;
        up_q[sel]     <= new_up;
        down_q[sel]   <= new_down;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_accept) begin
      req_floor_q <= floor_i;
    end
    if (out_load) begin
      accepted_q   <= out_accepted;
      car_id_q     <= out_car_id;
      car_floor_q  <= out_accepted ? new_floor : '0;
      motion_out_q <= out_accepted ? new_motion : MOT_IDLE;
      doors_open_q <= (state_q == ST_TICK) ? new_door : 1'b0;
      last_q       <= out_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = accepted_q;
  assign car_id_o     = car_id_q;
  assign car_floor_o  = car_floor_q;
  assign motion_o     = motion_out_q;
  assign doors_open_o = doors_open_q;
  assign last_o       = last_q;

  // Car 0, when idle, never holds a pending stop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    motion_q[0] == MOT_IDLE |-> (up_q[0] == '0) && (down_q[0] == '0))
    else $error("Idle car holds pending stops.");

  // The floor of car 0 stays within 1 to MAX_FLOORS.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (floor_q[0] != '0) && (floor_q[0] <= MAX_FLOOR_VAL))
    else $error("Car floor out of range.");

  // Only tick status results are not last, and they always name a car.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> accepted_o && (car_id_o != '0))
    else $error("Intermediate result without a car.");

  // A rejected request reports a zero car id and floor and closed doors.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> (car_id_o == '0) && (car_floor_o == '0) && !doors_open_o)
    else $error("Rejected result carries data.");

  // The search and the update never run while a new transaction can enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    car_we |-> in_stall_o)
    else $error("Car state written while accepting input.");

endmodule
